// File: rtl/wgm_pkg.sv
package wgm_pkg;

  localparam int SUBJ_W       = 16;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int LEN_REG_W    = 5;
  localparam int WORD_CHARS   = 4;
  localparam int PCHAR_W      = 16;
  localparam int OUT_DATA_W   = 8;

  localparam logic [SUBJ_W-1:0] CH_STAR     = 16'h002A;
  localparam logic [SUBJ_W-1:0] CH_QUESTION = 16'h003F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_WORD_0 = 3'd0,
    REG_PATTERN_WORD_1 = 3'd1,
    REG_PATTERN_WORD_2 = 3'd2,
    REG_PATTERN_WORD_3 = 3'd3,
    REG_PATTERN_LENGTH = 3'd4
  } cfg_reg_e;

  // one subject word held in the input register
  typedef struct packed {
    logic              last_char;
    logic [SUBJ_W-1:0] subject_char;
  } wgm_word_t;

endpackage

// File: rtl/wildcard_glob_matcher_core.sv
// channel | direction | handshake         | content
// in_     | input     | tvalid / tready   | tdata[15:0] subject_char, tlast last_char
// out_    | output    | tvalid / tready   | tdata[0] matched, upper bits zero
// cfg_    | input     | valid / ready     | index selects register, data is the value
//
// one word per cycle sustained while no last word waits on a stalled result; a word
// passes an input register, then the active-position update and star closure; a last
// word then passes the result register
// rst_n is synchronous: empty pattern, length 0, start state, no result pending
// a stalled result blocks the input only while a last word waits behind it
// cfg_ready is always high
module wildcard_glob_matcher_core #(
  parameter int PATTERN_MAX = 16,
  parameter int CHAR_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [wgm_pkg::SUBJ_W-1:0]        in_tdata,   // [15:0] subject_char
  input  logic                              in_tlast,   // last_char
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [wgm_pkg::OUT_DATA_W-1:0]    out_tdata,  // [0] matched, [7:1] zero
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wgm_pkg::*;

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int VEC_W = PATTERN_MAX + 1;

  logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] pat_chars;
  logic [LEN_W-1:0]                      pat_len;

  wgm_word_t        inq_r;
  logic             inq_valid_r;
  logic             inq_valid_nxt;
  logic [VEC_W-1:0] active_r;
  logic             at_start_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_matched_r;
  logic [VEC_W-1:0] next_vec;
  logic             matched;
  logic             in_fire;
  logic             consume;
  logic             load_out;

  assign cfg_ready = 1'b1;

  wgm_pattern_regs #(
    .PATTERN_MAX (PATTERN_MAX),
    .CHAR_BITS   (CHAR_BITS)
  ) u_pattern (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .pat_chars (pat_chars),
    .pat_len   (pat_len)
  );

  wgm_step #(
    .PATTERN_MAX (PATTERN_MAX),
    .CHAR_BITS   (CHAR_BITS)
  ) u_step (
    .pat_chars (pat_chars),
    .pat_len   (pat_len),
    .active    (active_r),
    .at_start  (at_start_r),
    .word      (inq_r),
    .next_vec  (next_vec),
    .matched   (matched)
  );

  // a last word needs room in the result register, others always move on
  assign consume   = inq_valid_r && (!inq_r.last_char || !out_valid_r || out_tready);
  assign load_out  = consume && inq_r.last_char;
  assign in_tready = !inq_valid_r || consume;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    inq_valid_nxt = inq_valid_r;
    if (in_fire) begin
      inq_valid_nxt = 1'b1;
    end else if (consume) begin
      inq_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      at_start_r  <= 1'b1;
    end else begin
      inq_valid_r <= inq_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (consume) begin
        at_start_r <= inq_r.last_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_r.subject_char <= in_tdata;
      inq_r.last_char    <= in_tlast;
    end
    if (consume) begin
      active_r <= next_vec;
    end
    if (load_out) begin
      out_matched_r <= matched;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 1){1'b0}}, out_matched_r};

  a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> at_start_r)
    else $error("block did not return to start state after last word");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (inq_valid_r && inq_r.last_char && out_valid_r && !out_tready))
    else $error("input stalled without a blocked last word");

endmodule

// File: rtl/wgm_pattern_regs.sv
module wgm_pattern_regs #(
  parameter int PATTERN_MAX = 16,
  parameter int CHAR_BITS   = 16,
  localparam int LEN_W      = $clog2(PATTERN_MAX + 1)
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    wr_en,
  input  logic [wgm_pkg::CFG_IDX_W-1:0]           wr_index,
  input  logic [wgm_pkg::CFG_DATA_W-1:0]          wr_data,
  output logic [PATTERN_MAX-1:0][CHAR_BITS-1:0]   pat_chars,
  output logic [LEN_W-1:0]                        pat_len
);
  import wgm_pkg::*;

  logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] chars_r;
  logic [LEN_REG_W-1:0]                  len_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r   <= '0;
      len_raw_r <= '0;
    end else if (wr_en) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        if (wr_index == (CFG_IDX_W'(REG_PATTERN_WORD_0) + CFG_IDX_W'(i >> 2))) begin
          chars_r[i] <= wr_data[PCHAR_W*(i & (WORD_CHARS - 1)) +: CHAR_BITS];
        end
      end
      if (wr_index == REG_PATTERN_LENGTH) begin
        len_raw_r <= wr_data[LEN_REG_W-1:0];
      end
    end
  end

  // lengths beyond the pattern store saturate
  always_comb begin
    if (len_raw_r > LEN_REG_W'(PATTERN_MAX)) begin
      pat_len = LEN_W'(PATTERN_MAX);
    end else begin
      pat_len = len_raw_r[LEN_W-1:0];
    end
  end

  assign pat_chars = chars_r;

endmodule

// File: rtl/wgm_step.sv
module wgm_step #(
  parameter int PATTERN_MAX = 16,
  parameter int CHAR_BITS   = 16,
  localparam int LEN_W      = $clog2(PATTERN_MAX + 1),
  localparam int VEC_W      = PATTERN_MAX + 1
) (
  input  logic [PATTERN_MAX-1:0][CHAR_BITS-1:0] pat_chars,
  input  logic [LEN_W-1:0]                      pat_len,
  input  logic [VEC_W-1:0]                      active,
  input  logic                                  at_start,
  input  wgm_pkg::wgm_word_t                    word,
  output logic [VEC_W-1:0]                      next_vec,
  output logic                                  matched
);
  import wgm_pkg::*;

  localparam int STEPS = $clog2(VEC_W);

  logic [VEC_W-1:0]       vmask;
  logic [VEC_W-1:0]       link;
  logic [VEC_W-1:0]       start_vec;
  logic [VEC_W-1:0]       cur_vec;
  logic [VEC_W-1:0]       step_vec;
  logic [PATTERN_MAX-1:0] is_star;
  logic [PATTERN_MAX-1:0] hit;

  // star closure as a parallel prefix: link[i] carries bit i-1 into bit i
  function automatic logic [VEC_W-1:0] close_stars(input logic [VEC_W-1:0] v,
                                                   input logic [VEC_W-1:0] lk);
    logic [VEC_W-1:0] g;
    logic [VEC_W-1:0] p;
    logic [VEC_W-1:0] g_n;
    logic [VEC_W-1:0] p_n;
    g = v;
    p = lk;
    for (int s = 0; s < STEPS; s++) begin
      g_n = g | (p & (g << (1 << s)));
      p_n = p & (p << (1 << s));
      g   = g_n;
      p   = p_n;
    end
    return g;
  endfunction

  always_comb begin
    link = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      is_star[i] = (LEN_W'(i) < pat_len) && (pat_chars[i] == CH_STAR[CHAR_BITS-1:0]);
      hit[i]     = (LEN_W'(i) < pat_len) && !is_star[i] &&
                   ((pat_chars[i] == CH_QUESTION[CHAR_BITS-1:0]) ||
                    (pat_chars[i] == word.subject_char[CHAR_BITS-1:0]));
      link[i+1]  = is_star[i];
    end
    for (int i = 0; i < VEC_W; i++) begin
      vmask[i] = (LEN_W'(i) <= pat_len);
    end
  end

  always_comb begin
    start_vec = close_stars(VEC_W'(1), link) & vmask;
    cur_vec   = at_start ? start_vec : (active & vmask);
    step_vec  = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      step_vec[i]   = step_vec[i] | (cur_vec[i] & is_star[i]);
      step_vec[i+1] = cur_vec[i] & hit[i];
    end
    next_vec = close_stars(step_vec, link) & vmask;
    matched  = next_vec[pat_len];
  end

endmodule
